// ----- rtl/artti_pkg.sv -----
package artti_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int OUT_WIDTH = 64;
   localparam int CHAR_WIDTH = 8;
   localparam int RADIX_WIDTH = 6;
   localparam int DIGIT_WIDTH = 6;

   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 6'd36;
   localparam logic [DIGIT_WIDTH-1:0] NOT_A_DIGIT = 6'd36;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_NO_DIGIT = 2'd2,
      STATUS_BAD_RADIX = 2'd3
   } status_type;

   function automatic logic is_skipped(input logic [CHAR_WIDTH-1:0] c);
      return (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) || (c == 8'h0C) ||
             (c == 8'h0D) || (c == 8'h20) || (c == 8'h2B) || (c == 8'h5F);
   endfunction

   // digit value 0..35, NOT_A_DIGIT for anything else
   function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] d;
      d = CHAR_WIDTH'(NOT_A_DIGIT);
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41 + 8'd10;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h61 + 8'd10;
      end
      return d[DIGIT_WIDTH-1:0];
   endfunction

endpackage

// ----- rtl/artti_req_if.sv -----
interface artti_req_if
   import artti_pkg::*;
   ();
   logic valid;
   logic ready;
   logic [CHAR_WIDTH-1:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink (input valid, input char_byte, output ready);
endinterface

// ----- rtl/artti_rsp_if.sv -----
interface artti_rsp_if
   import artti_pkg::*;
   ();
   logic valid;
   logic ready;
   logic signed [OUT_WIDTH-1:0] value;
   status_type status;

   modport source (output valid, output value, output status, input ready);
   modport sink (input valid, input value, input status, output ready);
endinterface

// ----- rtl/artti_csr_if.sv -----
interface artti_csr_if
   import artti_pkg::*;
   ();
   logic valid;
   logic ready;
   logic [RADIX_WIDTH-1:0] radix;

   modport source (output valid, output radix, input ready);
   modport sink (input valid, input radix, output ready);
endinterface

// ----- rtl/any_radix_text_to_integer.sv -----
// Radix text-to-integer converter.
// req_chan carries one string byte per transfer; a zero byte ends the string.
// rsp_chan carries one transfer per string: the signed 64-bit value and a
// status (ok, no significant characters, no valid digit, bad radix).
// csr_chan writes the radix register (reset 10); it is always ready and is
// meant to be written while no string is in progress.
// Throughput is one byte per cycle: the accumulator multiply-add by the radix
// sits in one stage between the input register and the accumulator register.
// rsp_chan.valid rises when the result loads: the terminator first sits in
// the input register, and fires from there into the result register.
// When the receiver stalls, the result holds in the result register and
// bytes keep flowing; ready drops only while a terminator waits in the
// input register behind a result that has not been taken yet.
// Reset (synchronous) empties both registers, sets the radix to 10 and
// clears the parse state.
module any_radix_text_to_integer
   import artti_pkg::*;
   #(
      parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
   ) (
      input logic clock,
      input logic reset,
      artti_req_if.sink req_chan,
      artti_rsp_if.source rsp_chan,
      artti_csr_if.sink csr_chan
   );

   logic [RADIX_WIDTH-1:0] radix_ff;

   logic byte_valid_ff;
   logic [CHAR_WIDTH-1:0] byte_ff;

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic neg_ff, neg_in;
   logic sig_ff, sig_in;
   logic dig_ff, dig_in;
   logic stop_ff, stop_in;

   logic rsp_valid_ff;
   logic signed [OUT_WIDTH-1:0] value_ff, value_in;
   status_type status_ff, status_in;

   logic is_term, advance, fire, rsp_take;
   logic [DIGIT_WIDTH-1:0] digit;
   logic [VALUE_WIDTH-1:0] product;
   logic signed [VALUE_WIDTH-1:0] signed_acc;
   logic radix_bad;

   assign is_term = (byte_ff == CHAR_NUL);
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;
   // only a terminator needs room in the result register
   assign advance = !is_term || !rsp_valid_ff || rsp_chan.ready;
   assign fire = byte_valid_ff && advance;

   assign req_chan.ready = !byte_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign digit = digit_of(byte_ff);
   assign product = VALUE_WIDTH'(acc_ff * {{(VALUE_WIDTH-RADIX_WIDTH){1'b0}}, radix_ff});
   assign signed_acc = neg_ff ? -acc_ff : acc_ff;
   assign radix_bad = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);

   always_comb begin
      acc_in = acc_ff;
      neg_in = neg_ff;
      sig_in = sig_ff;
      dig_in = dig_ff;
      stop_in = stop_ff;
      value_in = value_ff;
      status_in = status_ff;
      if (fire) begin
         if (is_term) begin
            if (radix_bad) begin
               value_in = '0;
               status_in = STATUS_BAD_RADIX;
            end else begin
               value_in = OUT_WIDTH'(signed_acc);
               status_in = dig_ff ? STATUS_OK : (sig_ff ? STATUS_NO_DIGIT : STATUS_EMPTY);
            end
            acc_in = '0;
            neg_in = 1'b0;
            sig_in = 1'b0;
            dig_in = 1'b0;
            stop_in = 1'b0;
         end else if (!stop_ff) begin
            if (byte_ff == CHAR_MINUS) begin
               neg_in = 1'b1;
            end else if (!is_skipped(byte_ff)) begin
               sig_in = 1'b1;
               if (digit >= NOT_A_DIGIT || digit >= radix_ff) begin
                  stop_in = 1'b1;
               end else begin
                  dig_in = 1'b1;
                  acc_in = product + {{(VALUE_WIDTH-DIGIT_WIDTH){1'b0}}, digit};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         byte_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff <= '0;
         neg_ff <= 1'b0;
         sig_ff <= 1'b0;
         dig_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            radix_ff <= csr_chan.radix;
         end
         if (req_chan.ready) begin
            byte_valid_ff <= req_chan.valid;
         end
         if (fire && is_term) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         sig_ff <= sig_in;
         dig_ff <= dig_in;
         stop_ff <= stop_in;
      end
   end

   // payload registers: hold until the next transfer
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         byte_ff <= req_chan.char_byte;
      end
      value_ff <= value_in;
      status_ff <= status_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = value_ff;
   assign rsp_chan.status = status_ff;

endmodule

// ----- tb/tb_any_radix_text_to_integer.sv -----
module tb_any_radix_text_to_integer;
   import artti_pkg::*;

   typedef struct {
      logic signed [OUT_WIDTH-1:0] value;
      status_type status;
   } parse_result_type;

   logic clock;
   logic reset;

   artti_req_if req_if();
   artti_rsp_if rsp_if();
   artti_csr_if csr_if();

   any_radix_text_to_integer dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_chan(csr_if)
   );

   // parser state as the block should hold it
   logic [RADIX_WIDTH-1:0] model_radix;
   logic [OUT_WIDTH-1:0] sum_acc;
   logic negative;
   logic seen_significant;
   logic seen_digit;
   logic halted;

   parse_result_type expected_results[$];
   int mismatch_count = 0;
   int sent_chars = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic logic [CHAR_WIDTH-1:0] blank_char(input int i);
      case (i)
         0: return 8'h09;
         1: return 8'h0A;
         2: return 8'h0B;
         3: return 8'h0C;
         4: return 8'h0D;
         5: return " ";
         6: return "+";
         default: return "_";
      endcase
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input int d, input bit lower);
      if (d < 10) return CHAR_WIDTH'("0" + d);
      return CHAR_WIDTH'((lower ? "a" : "A") + d - 10);
   endfunction

   function automatic void clear_parse_state();
      sum_acc = '0;
      negative = 1'b0;
      seen_significant = 1'b0;
      seen_digit = 1'b0;
      halted = 1'b0;
   endfunction

   // advance the parser by one byte; a terminator queues one result
   function automatic void parse_char(input logic [CHAR_WIDTH-1:0] c);
      parse_result_type r;
      int d;
      if (c == CHAR_NUL) begin
         if (model_radix < RADIX_MIN || model_radix > RADIX_MAX) begin
            r.value = '0;
            r.status = STATUS_BAD_RADIX;
         end else begin
            r.value = negative ? -sum_acc : sum_acc;
            r.status = seen_digit ? STATUS_OK :
                       (seen_significant ? STATUS_NO_DIGIT : STATUS_EMPTY);
         end
         expected_results.push_back(r);
         clear_parse_state();
         return;
      end
      if (halted) return;
      if (c == CHAR_MINUS) begin
         negative = 1'b1;
         return;
      end
      for (int i = 0; i < 8; i++) begin
         if (c == blank_char(i)) return;
      end
      seen_significant = 1'b1;
      if (c >= "0" && c <= "9") d = int'(c - "0");
      else if (c >= "A" && c <= "Z") d = int'(c - "A") + 10;
      else if (c >= "a" && c <= "z") d = int'(c - "a") + 10;
      else d = int'(NOT_A_DIGIT);
      if (d >= NOT_A_DIGIT || d >= model_radix) begin
         halted = 1'b1;
         return;
      end
      seen_digit = 1'b1;
      sum_acc = sum_acc * OUT_WIDTH'(model_radix) + OUT_WIDTH'(d);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_char(input logic [CHAR_WIDTH-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.char_byte <= c;
      do @(posedge clock); while (!req_if.ready);
      parse_char(c);
      sent_chars++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // hold the sender until every result is back and the pipe has drained
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_WIDTH-1:0] r);
      csr_if.valid <= 1'b1;
      csr_if.radix <= r;
      do @(posedge clock); while (!csr_if.ready);
      model_radix = r;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [RADIX_WIDTH-1:0] pick_radix();
      if ($urandom_range(99) < 15) begin
         return RADIX_WIDTH'($urandom_range(1) ? $urandom_range(1) : $urandom_range(63, 37));
      end
      return RADIX_WIDTH'($urandom_range(36, 2));
   endfunction

   task automatic send_random_string();
      int kind;
      int n;
      int d;
      int top;
      kind = $urandom_range(99);
      top = (model_radix >= RADIX_MIN && model_radix <= RADIX_MAX) ?
            int'(model_radix) - 1 : 35;
      if (kind < 15) begin
         // noise: arbitrary non-terminator bytes
         n = $urandom_range(12);
         repeat (n) send_char(CHAR_WIDTH'($urandom_range(255, 1)));
      end else begin
         n = $urandom_range(3);
         repeat (n) send_char(blank_char($urandom_range(7)));
         case ($urandom_range(3))
            0: send_char(CHAR_MINUS);
            1: send_char("+");
            2: send_text("--");
            default: ;
         endcase
         // long digit runs can wrap the accumulator
         n = (kind < 30) ? $urandom_range(24, 14) : $urandom_range(8, 1);
         repeat (n) begin
            if ($urandom_range(99) < 8) send_char($urandom_range(1) ? "_" : CHAR_MINUS);
            d = $urandom_range(top);
            send_char(digit_char(d, 1'($urandom_range(1))));
         end
         if ($urandom_range(99) < 30) begin
            if (top < 35 && $urandom_range(1)) begin
               send_char(digit_char($urandom_range(35, top + 1), 1'($urandom_range(1))));
            end else begin
               send_char($urandom_range(1) ? "*" : 8'hFF);
            end
            n = $urandom_range(4);
            repeat (n) send_char(CHAR_WIDTH'($urandom_range(255, 1)));
         end
      end
      send_char(CHAR_NUL);
   endtask

   task automatic test_empty_and_signs();
      send_char(CHAR_NUL);
      // skipped bytes, sign, digit, high byte stops, trailing digit ignored
      send_text("\n+_-9");
      send_char(8'h0D);
      send_char(8'hFF);
      send_text("5");
      send_char(CHAR_NUL);
      send_text("x");
      send_char(CHAR_NUL);
      wait_idle();
   endtask

   task automatic test_radix_extremes();
      write_radix(RADIX_MAX);
      send_text("zZ-");
      send_char(CHAR_NUL);
      wait_idle();
      write_radix(RADIX_MIN);
      send_text("12");
      send_char(CHAR_NUL);
      wait_idle();
      write_radix('1);
      send_text("1");
      send_char(CHAR_NUL);
      wait_idle();
      write_radix('0);
      send_char(CHAR_NUL);
      wait_idle();
   endtask

   task automatic test_radix_change_mid_string();
      write_radix(6'd10);
      send_text("7");
      wait_idle();
      write_radix(6'd16);
      send_text("f");
      send_char(CHAR_NUL);
      wait_idle();
      // radix of one stops at the first nonzero digit
      write_radix(6'd1);
      send_text("5");
      wait_idle();
      write_radix(6'd10);
      send_text("6");
      send_char(CHAR_NUL);
      wait_idle();
   endtask

   task automatic test_random_text(input int send_pct, input int recv_pct,
                                   input int char_budget);
      int strings;
      int stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = sent_chars + char_budget;
      strings = 0;
      while (sent_chars < stop_at) begin
         if (strings % 6 == 0) begin
            wait_idle();
            write_radix(pick_radix());
         end
         send_random_string();
         strings++;
      end
      wait_idle();
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      parse_result_type exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result value=%0d status=%s",
                                    rsp_if.value, rsp_if.status.name()));
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_if.value !== exp_r.value) begin
               flag_mismatch($sformatf("value %0d, expected %0d",
                                       rsp_if.value, exp_r.value));
            end
            if (rsp_if.status !== exp_r.status) begin
               flag_mismatch($sformatf("status %s, expected %s",
                                       rsp_if.status.name(), exp_r.status.name()));
            end
         end
      end
   end

   initial begin
      int guard;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.char_byte = '0;
      csr_if.valid = 1'b0;
      csr_if.radix = '0;
      model_radix = RADIX_RESET;
      clear_parse_state();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_and_signs();
      test_radix_extremes();
      test_radix_change_mid_string();
      test_random_text(8, 81, 215);
      test_random_text(81, 8, 215);
      test_random_text(0, 0, 215);

      guard = 0;
      while (expected_results.size() != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
      if (expected_results.size() != 0) begin
         flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/artti_pkg.sv
rtl/artti_req_if.sv
rtl/artti_rsp_if.sv
rtl/artti_csr_if.sv
rtl/any_radix_text_to_integer.sv
tb/tb_any_radix_text_to_integer.sv
